@@ design/i2cms_pkg.sv @@
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

  // Command codes carried in the func field
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_BEGIN_RD = 2'd1;
  localparam logic [1:0] FUNC_BEGIN_WR = 2'd2;
  localparam logic [1:0] FUNC_SUPPLY   = 2'd3;

  // Completion status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;

  // Configuration port geometry and register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_HALF_PERIOD = 1'b0;
  localparam logic [7:0]  HALF_PERIOD_RST = 8'd2;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE          = 4'd0,
    PH_START_HIGH    = 4'd1,
    PH_START_LOW     = 4'd2,
    PH_SLOT_LOW      = 4'd3,
    PH_SLOT_SET      = 4'd4,
    PH_SLOT_HIGH     = 4'd5,
    PH_WAIT          = 4'd6,
    PH_STOP_SCL_LOW  = 4'd7,
    PH_STOP_SDA_LOW  = 4'd8,
    PH_STOP_SCL_HIGH = 4'd9,
    PH_STOP_SDA_HIGH = 4'd10
  } phase_e;

  // Input beat
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] address_byte;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_sample;
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_write_byte;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] bytes_done;
    logic       busy_res;
  } res_t;

  // Sequencer state
  typedef struct packed {
    phase_e     phase;
    logic [8:0] tick_cnt;
    logic [3:0] bit_idx;
    logic [7:0] byte_idx;
    logic [7:0] total_bytes;
    logic [7:0] shreg;
    logic       ack_seen;
    logic       is_read;
    logic       scl_drive;
    logic       sda_drive;
    logic       in_addr;
  } seq_state_t;

endpackage

@@ design/i2cms_chan_if.sv @@
// Valid/ready channel interface carrying one beat of a given payload type.
interface i2cms_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/i2cms_apb_regs.sv @@
// APB configuration register: half bit period in ticks.
module i2cms_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [i2cms_pkg::PADDR_W-1:0]       paddr,
  input  logic [i2cms_pkg::PDATA_W-1:0]       pwdata,
  output logic [i2cms_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  output logic [7:0]                          half_period_o
);

  logic [7:0] half_period_q;
  logic       reg_sel;
  logic       wr_en;

  // word index; byte offset bits are ignored
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && (reg_sel == i2cms_pkg::REG_HALF_PERIOD);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= i2cms_pkg::HALF_PERIOD_RST;
    end else if (wr_en) begin
      half_period_q <= pwdata[7:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_sel == i2cms_pkg::REG_HALF_PERIOD) begin
      prdata = {{(i2cms_pkg::PDATA_W-8){1'b0}}, half_period_q};
    end
  end

  assign half_period_o = half_period_q;

endmodule

@@ design/i2cms_seq.sv @@
// Bus sequencer: state registers and the per-beat next-state/result logic.
module i2cms_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  i2cms_pkg::cmd_t cmd_i,
  input  logic [7:0]      half_period_i,
  output i2cms_pkg::res_t res_o
);

  i2cms_pkg::seq_state_t st_q, st_d;

  logic [8:0] half_len;
  logic [8:0] slot_len;
  logic [8:0] cnt_inc;
  logic       rcv;
  logic       rv_valid;
  logic [7:0] rv_byte;
  logic       dn_flag;
  logic [1:0] dn_status;
  logic [7:0] dn_count;

  // zero half period acts as one
  assign half_len = (half_period_i == 8'd0) ? 9'd1 : {1'b0, half_period_i};

  // next step after a byte's ACK slot
  function automatic i2cms_pkg::phase_e next_byte_phase(
    input logic [7:0] byte_idx,
    input logic [7:0] total,
    input logic       is_read
  );
    i2cms_pkg::phase_e ph;
    if (byte_idx >= total) begin
      ph = i2cms_pkg::PH_STOP_SCL_LOW;
    end else if (is_read) begin
      ph = i2cms_pkg::PH_SLOT_LOW;
    end else begin
      ph = i2cms_pkg::PH_WAIT;
    end
    return ph;
  endfunction

  always_comb begin
    st_d      = st_q;
    rv_valid  = 1'b0;
    rv_byte   = 8'd0;
    dn_flag   = 1'b0;
    dn_status = i2cms_pkg::ST_OK;
    dn_count  = 8'd0;
    slot_len  = half_len;
    cnt_inc   = 9'd0;
    rcv       = st_q.is_read && !st_q.in_addr;

    case (cmd_i.func)
      i2cms_pkg::FUNC_TICK: begin
        if (st_d.phase == i2cms_pkg::PH_IDLE || st_d.phase == i2cms_pkg::PH_WAIT) begin
          // nothing advances
        end else if (st_d.phase > i2cms_pkg::PH_STOP_SDA_HIGH) begin
          st_d.phase = i2cms_pkg::PH_IDLE;
        end else begin
          // line levels set on the first tick of a phase
          if (st_d.tick_cnt == 9'd0) begin
            case (st_d.phase)
              i2cms_pkg::PH_START_HIGH: begin
                st_d.scl_drive = 1'b1;
                st_d.sda_drive = 1'b1;
              end
              i2cms_pkg::PH_START_LOW:     st_d.sda_drive = 1'b0;
              i2cms_pkg::PH_SLOT_LOW:      st_d.scl_drive = 1'b0;
              i2cms_pkg::PH_SLOT_SET: begin
                if (!st_d.bit_idx[3]) begin
                  st_d.sda_drive = rcv ? 1'b1 : st_d.shreg[7];
                end else begin
                  st_d.sda_drive = !rcv;
                end
              end
              i2cms_pkg::PH_SLOT_HIGH:     st_d.scl_drive = 1'b1;
              i2cms_pkg::PH_STOP_SCL_LOW:  st_d.scl_drive = 1'b0;
              i2cms_pkg::PH_STOP_SDA_LOW:  st_d.sda_drive = 1'b0;
              i2cms_pkg::PH_STOP_SCL_HIGH: st_d.scl_drive = 1'b1;
              i2cms_pkg::PH_STOP_SDA_HIGH: st_d.sda_drive = 1'b1;
              default: ;
            endcase
          end

          // SCL-high window: data sample mid-window, ACK seen on any low
          if (st_d.phase == i2cms_pkg::PH_SLOT_HIGH) begin
            slot_len = {half_len[7:0], 1'b0};
            if (!st_d.bit_idx[3]) begin
              if (rcv && st_d.tick_cnt == half_len) begin
                st_d.shreg = {st_d.shreg[6:0], cmd_i.sda_sample};
              end
            end else if (!rcv && !cmd_i.sda_sample) begin
              st_d.ack_seen = 1'b1;
            end
          end

          cnt_inc = st_d.tick_cnt + 9'd1;
          if (cnt_inc < slot_len) begin
            st_d.tick_cnt = cnt_inc;
          end else begin
            st_d.tick_cnt = 9'd0;
            case (st_d.phase)
              i2cms_pkg::PH_START_HIGH:    st_d.phase = i2cms_pkg::PH_START_LOW;
              i2cms_pkg::PH_START_LOW:     st_d.phase = i2cms_pkg::PH_SLOT_LOW;
              i2cms_pkg::PH_SLOT_LOW:      st_d.phase = i2cms_pkg::PH_SLOT_SET;
              i2cms_pkg::PH_SLOT_SET:      st_d.phase = i2cms_pkg::PH_SLOT_HIGH;
              i2cms_pkg::PH_STOP_SCL_LOW:  st_d.phase = i2cms_pkg::PH_STOP_SDA_LOW;
              i2cms_pkg::PH_STOP_SDA_LOW:  st_d.phase = i2cms_pkg::PH_STOP_SCL_HIGH;
              i2cms_pkg::PH_STOP_SCL_HIGH: st_d.phase = i2cms_pkg::PH_STOP_SDA_HIGH;
              i2cms_pkg::PH_SLOT_HIGH: begin
                if (!st_d.bit_idx[3]) begin
                  // end of a data bit
                  if (!rcv) begin
                    st_d.shreg = {st_d.shreg[6:0], 1'b0};
                  end
                  st_d.bit_idx = st_d.bit_idx + 4'd1;
                  if (st_d.bit_idx[3]) begin
                    st_d.ack_seen = 1'b0;
                    if (rcv) begin
                      rv_valid = 1'b1;
                      rv_byte  = st_d.shreg;
                    end
                  end
                  st_d.phase = i2cms_pkg::PH_SLOT_LOW;
                end else if (st_d.in_addr) begin
                  // end of the address ACK slot
                  st_d.in_addr = 1'b0;
                  if (!st_d.ack_seen) begin
                    dn_flag    = 1'b1;
                    dn_status  = i2cms_pkg::ST_ADDR_NACK;
                    st_d.phase = i2cms_pkg::PH_IDLE;
                  end else begin
                    st_d.phase = next_byte_phase(st_d.byte_idx, st_d.total_bytes,
                                                 st_d.is_read);
                    if (st_d.phase == i2cms_pkg::PH_SLOT_LOW) begin
                      st_d.bit_idx = 4'd0;
                    end
                  end
                end else if (st_d.is_read) begin
                  st_d.byte_idx = st_d.byte_idx + 8'd1;
                  st_d.phase = next_byte_phase(st_d.byte_idx, st_d.total_bytes,
                                               st_d.is_read);
                  if (st_d.phase == i2cms_pkg::PH_SLOT_LOW) begin
                    st_d.bit_idx = 4'd0;
                  end
                end else if (!st_d.ack_seen) begin
                  // write byte not acknowledged
                  dn_flag    = 1'b1;
                  dn_status  = i2cms_pkg::ST_DATA_NACK;
                  dn_count   = st_d.byte_idx;
                  st_d.phase = i2cms_pkg::PH_IDLE;
                end else begin
                  st_d.byte_idx = st_d.byte_idx + 8'd1;
                  st_d.phase = next_byte_phase(st_d.byte_idx, st_d.total_bytes,
                                               st_d.is_read);
                end
              end
              default: begin
                // stop complete
                dn_flag    = 1'b1;
                dn_status  = i2cms_pkg::ST_OK;
                dn_count   = st_d.total_bytes;
                st_d.phase = i2cms_pkg::PH_IDLE;
              end
            endcase
          end
        end
      end

      i2cms_pkg::FUNC_SUPPLY: begin
        if (st_d.phase == i2cms_pkg::PH_WAIT) begin
          st_d.shreg    = cmd_i.write_byte;
          st_d.bit_idx  = 4'd0;
          st_d.tick_cnt = 9'd0;
          st_d.phase    = i2cms_pkg::PH_SLOT_LOW;
        end
      end

      default: begin
        // begin read or write, ignored while busy
        if (st_d.phase == i2cms_pkg::PH_IDLE) begin
          st_d.is_read     = (cmd_i.func == i2cms_pkg::FUNC_BEGIN_RD);
          st_d.shreg       = {cmd_i.address_byte[7:1], st_d.is_read};
          st_d.total_bytes = cmd_i.byte_count;
          st_d.byte_idx    = 8'd0;
          st_d.bit_idx     = 4'd0;
          st_d.ack_seen    = 1'b0;
          st_d.in_addr     = 1'b1;
          st_d.tick_cnt    = 9'd0;
          st_d.phase       = i2cms_pkg::PH_START_HIGH;
        end
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase       <= i2cms_pkg::PH_IDLE;
      st_q.tick_cnt    <= 9'd0;
      st_q.bit_idx     <= 4'd0;
      st_q.byte_idx    <= 8'd0;
      st_q.total_bytes <= 8'd0;
      st_q.shreg       <= 8'd0;
      st_q.ack_seen    <= 1'b0;
      st_q.is_read     <= 1'b0;
      st_q.scl_drive   <= 1'b1;
      st_q.sda_drive   <= 1'b1;
      st_q.in_addr     <= 1'b0;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

  // result of this beat
  always_comb begin
    res_o.scl_level       = st_d.scl_drive;
    res_o.sda_level       = st_d.sda_drive;
    res_o.read_byte       = rv_byte;
    res_o.read_valid      = rv_valid;
    res_o.need_write_byte = (st_d.phase == i2cms_pkg::PH_WAIT);
    res_o.done_res        = dn_flag;
    res_o.status          = dn_status;
    res_o.bytes_done      = dn_count;
    res_o.busy_res        = (st_d.phase != i2cms_pkg::PH_IDLE);
  end

endmodule

@@ design/i2c_master_bit_sequencer.sv @@
// I2C master bit sequencer: one command or tick beat in, one result beat out.
// Path: an accepted command beat is held in the input register, then its result in the result register;
//   the sequencer state updates as the beat crosses between them.
// Throughput: 1 beat per cycle while the result side is not stalled by res_o.ready low.
// Reset (rst_ni, async, active low): bus idle with both lines released, empty
//   pipeline, half period back to 2 ticks.
module i2c_master_bit_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  i2cms_chan_if.sink                     cmd_i,
  i2cms_chan_if.source                   res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i2cms_pkg::PADDR_W-1:0]  paddr,
  input  logic [i2cms_pkg::PDATA_W-1:0]  pwdata,
  output logic [i2cms_pkg::PDATA_W-1:0]  prdata,
  output logic                           pready
);

  logic            cmd_v_q;
  i2cms_pkg::cmd_t cmd_q;
  logic            res_v_q;
  i2cms_pkg::res_t res_q;
  i2cms_pkg::res_t res_d;
  logic            advance;
  logic [7:0]      half_period;

  // configuration register
  i2cms_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .half_period_o (half_period)
  );

  // pipeline control: a beat moves on when the result register is free
  assign advance     = cmd_v_q && (!res_v_q || res_o.ready);
  assign cmd_i.ready = !cmd_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_v_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      if (cmd_i.ready) begin
        cmd_v_q <= cmd_i.valid;
      end
      if (advance) begin
        res_v_q <= 1'b1;
      end else if (res_o.ready) begin
        res_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q <= cmd_i.data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // sequencer step
  i2cms_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .cmd_i         (cmd_q),
    .half_period_i (half_period),
    .res_o         (res_d)
  );

  assign res_o.valid = res_v_q;
  assign res_o.data  = res_q;

  // a finished or aborted transfer is no longer busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.done_res |-> !res_o.data.busy_res)
    else $error("done beat reports busy");

  // received bytes only appear mid-transfer
  a_read_in_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.read_valid |-> res_o.data.busy_res && !res_o.data.done_res)
    else $error("read byte outside a transfer");

  // error status only accompanies completion
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.status != i2cms_pkg::ST_OK |-> res_o.data.done_res)
    else $error("status without done");

  // a beat waiting in the input register moves once the output side drains
  a_pipe_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_v_q && !res_v_q |=> res_v_q)
    else $error("pipeline failed to advance");

endmodule
